[rtl/chm_pkg.sv]
// Shared types, constants and codes for the coldest-hour-by-mean block.
package chm_pkg;

    localparam int NUM_BINS    = 24;
    localparam int COUNT_WIDTH = 16;
    localparam int TEMP_W      = 8;
    localparam int HOUR_W      = 5;
    localparam int SUM_W       = COUNT_WIDTH + TEMP_W;
    localparam int PROD_W      = SUM_W + COUNT_WIDTH + 1;
    localparam int IDX_W       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    localparam logic signed [TEMP_W-1:0] CEIL_RESET = 8'sd100;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic [HOUR_W-1:0]        hour;
        logic signed [TEMP_W-1:0] temperature;
    } in_t;

    typedef struct packed {
        logic [HOUR_W-1:0] coldest_hour;
        logic              found;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_DONE
    } state_t;

    // Scan unit control from the sequencer.
    typedef struct packed {
        logic start;
        logic mul_en;
        logic cmp_en;
    } scan_ctl_t;

endpackage

[rtl/chm_cell.sv]
// One bin cell: holds a bin's sum and count, adds samples, shifts toward the head.
module chm_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             add_hit,
    input  logic signed [chm_pkg::TEMP_W-1:0] temperature,
    input  logic                             shift,
    input  logic signed [chm_pkg::SUM_W-1:0] nbr_sum,
    input  logic [chm_pkg::COUNT_WIDTH-1:0]  nbr_count,
    output logic signed [chm_pkg::SUM_W-1:0] sum,
    output logic [chm_pkg::COUNT_WIDTH-1:0]  count
);

    logic signed [chm_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [chm_pkg::COUNT_WIDTH-1:0]  count_reg, count_next;

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (shift)
        begin
            sum_next   = nbr_sum;
            count_next = nbr_count;
        end
        else if (add_hit && (count_reg != '1))
        begin
            // saturated bins drop the sample
            sum_next   = sum_reg + chm_pkg::SUM_W'(temperature);
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    assign sum   = sum_reg;
    assign count = count_reg;

endmodule

[rtl/chm_scan.sv]
// Running arg-min over the head cell: cross-multiplied mean compare.
module chm_scan (
    input  logic                              clk,
    input  logic                              rst_n,
    input  chm_pkg::scan_ctl_t                ctl,
    input  logic signed [chm_pkg::TEMP_W-1:0] ceiling,
    input  logic signed [chm_pkg::SUM_W-1:0]  head_sum,
    input  logic [chm_pkg::COUNT_WIDTH-1:0]   head_count,
    input  logic [chm_pkg::IDX_W-1:0]         idx,
    output logic                              found,
    output logic [chm_pkg::IDX_W-1:0]         best_idx
);

    logic signed [chm_pkg::SUM_W-1:0]  best_sum_reg;
    logic [chm_pkg::COUNT_WIDTH-1:0]   best_cnt_reg;
    logic [chm_pkg::IDX_W-1:0]         best_idx_reg;
    logic                              found_reg;
    logic signed [chm_pkg::PROD_W-1:0] p_cand_reg, p_best_reg;
    logic signed [chm_pkg::COUNT_WIDTH:0] best_cnt_ext, head_cnt_ext;
    logic                              better;

    assign best_cnt_ext = $signed({1'b0, best_cnt_reg});
    assign head_cnt_ext = $signed({1'b0, head_count});

    // cand/cnt_c < best/cnt_b  <=>  cand*cnt_b < best*cnt_c (counts positive)
    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            p_cand_reg <= chm_pkg::PROD_W'(head_sum * best_cnt_ext);
            p_best_reg <= chm_pkg::PROD_W'(best_sum_reg * head_cnt_ext);
        end
    end

    assign better = (head_count != '0) && (p_cand_reg < p_best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            best_idx_reg <= '0;
            best_sum_reg <= '0;
            best_cnt_reg <= '0;
        end
        else if (ctl.start)
        begin
            found_reg    <= 1'b0;
            best_idx_reg <= '0;
            best_sum_reg <= chm_pkg::SUM_W'(ceiling);
            best_cnt_reg <= chm_pkg::COUNT_WIDTH'(1);
        end
        else if (ctl.cmp_en && better)
        begin
            found_reg    <= 1'b1;
            best_idx_reg <= idx;
            best_sum_reg <= head_sum;
            best_cnt_reg <= head_count;
        end
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;

endmodule

[rtl/coldest_hour_by_mean_top.sv]
// Top level: bin cell row, scan unit, sequencer, output register and ceiling register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  in       | in_valid / in_ready  | in_data  (cmd, hour, temperature)
//  out      | out_valid / out_ready| out_data (coldest_hour, found)
//  cfg      | cfg_we (no wait)     | cfg_wdata (initial_ceiling)
//
// Samples can be accepted every cycle while the sequencer is idle. A finish
// walks the cell row bin by bin: ST_MUL multiplies, then ST_CMP compares and
// updates while the row shifts the next bin into the head; after the last bin,
// ST_DONE loads the output register. The shift also clears the row.
// Reset clears every bin and the output valid flag, and sets the ceiling to 100.
// The result waits in the output register; samples are still accepted while it
// waits, but a new finish holds until the pending result is taken.
module coldest_hour_by_mean_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  chm_pkg::in_t                      in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output chm_pkg::out_t                     out_data,
    input  logic                              cfg_we,
    input  logic signed [chm_pkg::TEMP_W-1:0] cfg_wdata
);

    chm_pkg::state_t state_reg, state_next;
    logic [chm_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic signed [chm_pkg::TEMP_W-1:0] ceiling_reg;
    logic out_valid_reg;
    chm_pkg::out_t out_data_reg;

    chm_pkg::scan_ctl_t scan_ctl;
    logic shift;
    logic in_fire, add_en;
    logic scan_found;
    logic [chm_pkg::IDX_W-1:0] scan_idx;

    logic signed [chm_pkg::SUM_W-1:0] cell_sum   [chm_pkg::NUM_BINS+1];
    logic [chm_pkg::COUNT_WIDTH-1:0]  cell_count [chm_pkg::NUM_BINS+1];

    // -------- config register --------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ceiling_reg <= chm_pkg::CEIL_RESET;
        else if (cfg_we)
            ceiling_reg <= cfg_wdata;
    end

    // -------- input handshake --------
    // a finish waits while a result is still pending
    assign in_ready = (state_reg == chm_pkg::ST_IDLE) &&
                      !((in_data.cmd == chm_pkg::CMD_FINISH) && out_valid_reg);
    assign in_fire  = in_valid && in_ready;
    assign add_en   = in_fire && (in_data.cmd == chm_pkg::CMD_ADD);

    // -------- cell row; the entry past the tail feeds zeros --------
    assign cell_sum[chm_pkg::NUM_BINS]   = '0;
    assign cell_count[chm_pkg::NUM_BINS] = '0;

    for (genvar i = 0; i < chm_pkg::NUM_BINS; i++)
    begin : g_cell
        logic hit;
        // hours past the last bin match no cell and drop
        assign hit = add_en && (32'(in_data.hour) == i);

        chm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .add_hit     (hit),
            .temperature (in_data.temperature),
            .shift       (shift),
            .nbr_sum     (cell_sum[i+1]),
            .nbr_count   (cell_count[i+1]),
            .sum         (cell_sum[i]),
            .count       (cell_count[i])
        );
    end

    // -------- scan unit on the head cell --------
    chm_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .ceiling    (ceiling_reg),
        .head_sum   (cell_sum[0]),
        .head_count (cell_count[0]),
        .idx        (idx_reg),
        .found      (scan_found),
        .best_idx   (scan_idx)
    );

    // -------- sequencer --------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chm_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        scan_ctl.start  = 1'b0;
        scan_ctl.mul_en = 1'b0;
        scan_ctl.cmp_en = 1'b0;
        shift           = 1'b0;
        case (state_reg)
            chm_pkg::ST_IDLE:
            begin
                if (in_fire && (in_data.cmd == chm_pkg::CMD_FINISH))
                begin
                    scan_ctl.start = 1'b1;
                    idx_next       = '0;
                    state_next     = chm_pkg::ST_MUL;
                end
            end
            chm_pkg::ST_MUL:
            begin
                scan_ctl.mul_en = 1'b1;
                state_next      = chm_pkg::ST_CMP;
            end
            chm_pkg::ST_CMP:
            begin
                scan_ctl.cmp_en = 1'b1;
                shift           = 1'b1;
                if (idx_reg == chm_pkg::IDX_W'(chm_pkg::NUM_BINS - 1))
                    state_next = chm_pkg::ST_DONE;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = chm_pkg::ST_MUL;
                end
            end
            chm_pkg::ST_DONE:
            begin
                state_next = chm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = chm_pkg::ST_IDLE;
            end
        endcase
    end

    // -------- output register --------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == chm_pkg::ST_DONE)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == chm_pkg::ST_DONE)
        begin
            out_data_reg.found        <= scan_found;
            out_data_reg.coldest_hour <= scan_found ? chm_pkg::HOUR_W'(scan_idx) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // -------- assertions --------
    a_finish_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_data.cmd == chm_pkg::CMD_FINISH))
            |-> ##(2*chm_pkg::NUM_BINS+1) (state_reg == chm_pkg::ST_DONE))
        else $error("finish transaction did not complete on schedule");

    a_row_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chm_pkg::ST_DONE)
            |-> ((cell_count[0] == '0) && (cell_count[chm_pkg::NUM_BINS-1] == '0)))
        else $error("bins not cleared after scan");

    a_done_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chm_pkg::ST_DONE) |-> !out_valid_reg)
        else $error("result overwrote a pending transaction");

    a_no_hour_when_absent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.found || (out_data.coldest_hour == '0)))
        else $error("hour set without found");

endmodule

[bench/testbench.sv]
// Self-checking bench for coldest_hour_by_mean_top: queued driver, monitor and mean predictor.
`timescale 1ns / 100ps

module testbench;

    // Run-time budget: under a thousand transactions, each at worst a full
    // finish walk under heavy stalls, taken many times over.
    localparam time RUN_LIMIT = 5ms;
    // A finish walks the whole cell row; this covers it with slack.
    localparam int DRAIN_CYCLES = 2 * chm_pkg::NUM_BINS + 12;
    localparam int SAT_COUNT = (1 << chm_pkg::COUNT_WIDTH) - 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    chm_pkg::in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    chm_pkg::out_t out_data;
    logic cfg_we = 1'b0;
    logic signed [chm_pkg::TEMP_W-1:0] cfg_wdata = '0;

    // Transactions waiting to be driven, and results the predictor has produced.
    chm_pkg::in_t txn_queue[$];
    chm_pkg::out_t coldest_queue[$];

    // Predictor state: one sum and count per hour, plus the ceiling mirror.
    longint hour_sum[chm_pkg::NUM_BINS];
    int unsigned hour_cnt[chm_pkg::NUM_BINS];
    int ceiling_mirror = chm_pkg::CEIL_RESET;

    // Idle odds in percent, set per phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;

    coldest_hour_by_mean_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Exact mean compare: sa/ca < sb/cb with both counts positive. Products
    // stay within 41 bits, so 64-bit arithmetic is exact.
    function automatic bit mean_below(longint sa, longint ca, longint sb, longint cb);
        return (sa * cb) < (sb * ca);
    endfunction

    // Apply one accepted transaction to the predictor. A sample updates its
    // bin unless the hour is out of range or the bin count is saturated; a
    // finish scans for the lowest mean below the ceiling and clears the bins.
    task automatic absorb_transaction(input chm_pkg::in_t txn);
        chm_pkg::out_t res;
        longint best_sum;
        longint best_cnt;
        if (txn.cmd == chm_pkg::CMD_ADD)
        begin
            if (txn.hour < chm_pkg::NUM_BINS && hour_cnt[txn.hour] < SAT_COUNT)
            begin
                hour_sum[txn.hour] += longint'(txn.temperature);
                hour_cnt[txn.hour] += 1;
            end
        end
        else
        begin
            res = '0;
            best_sum = ceiling_mirror;
            best_cnt = 1;
            for (int h = 0; h < chm_pkg::NUM_BINS; h++)
            begin
                // Strict compare: equal means keep the earlier hour.
                if (hour_cnt[h] != 0 &&
                    mean_below(hour_sum[h], hour_cnt[h], best_sum, best_cnt))
                begin
                    res.found = 1'b1;
                    res.coldest_hour = chm_pkg::HOUR_W'(h);
                    best_sum = hour_sum[h];
                    best_cnt = hour_cnt[h];
                end
            end
            for (int h = 0; h < chm_pkg::NUM_BINS; h++)
            begin
                hour_sum[h] = 0;
                hour_cnt[h] = 0;
            end
            coldest_queue.push_back(res);
        end
    endtask

    // Driver: present the next queued transaction once the current one is
    // taken (or the channel is empty), unless this cycle is chosen as a gap.
    // valid stays up with a stable payload until accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (txn_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data  <= txn_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: all sampled values are pre-edge, since every driver here and
    // in the block updates by nonblocking assignment.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                absorb_transaction(in_data);
            if (out_valid && out_ready)
            begin
                if (coldest_queue.size() == 0)
                begin
                    $display("%0t: unexpected result expected none actual hour %0d found %0d",
                             $time, out_data.coldest_hour, out_data.found);
                    error_count++;
                end
                else
                begin
                    if (out_data.found !== coldest_queue[0].found)
                    begin
                        $display("%0t: found mismatch expected %0d actual %0d",
                                 $time, coldest_queue[0].found, out_data.found);
                        error_count++;
                    end
                    if (out_data.coldest_hour !== coldest_queue[0].coldest_hour)
                    begin
                        $display("%0t: coldest_hour mismatch expected %0d actual %0d",
                                 $time, coldest_queue[0].coldest_hour, out_data.coldest_hour);
                        error_count++;
                    end
                    void'(coldest_queue.pop_front());
                end
            end
        end
    end

    function automatic chm_pkg::in_t make_txn(logic cmd, int hour, int temp);
        chm_pkg::in_t txn;
        txn.cmd = cmd;
        txn.hour = chm_pkg::HOUR_W'(hour);
        txn.temperature = chm_pkg::TEMP_W'(temp);
        return txn;
    endfunction

    // Block until everything queued is driven and every result is back, then
    // let a full finish latency pass so the block is surely idle.
    task automatic wait_quiet();
        while (txn_queue.size() != 0 || in_valid || coldest_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_ceiling(input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= chm_pkg::TEMP_W'(value);
        ceiling_mirror = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random traffic in segments. Each segment picks a few hot hours and a
    // base temperature so means land close together (ties, near-ceiling),
    // mixed with full-range values, out-of-range hours and scattered hits.
    task automatic fill_random_phase(input int n_items);
        int base;
        int temp;
        int hour;
        int roll;
        int hot[4];
        for (int k = 0; k < 4; k++)
            hot[k] = $urandom_range(chm_pkg::NUM_BINS - 1);
        base = int'($urandom_range(255)) - 128;
        for (int i = 0; i < n_items; i++)
        begin
            if (i == n_items - 1 || $urandom_range(11) == 0)
            begin
                // Finish with junk in the ignored fields.
                txn_queue.push_back(make_txn(chm_pkg::CMD_FINISH, $urandom_range(31),
                                             $urandom_range(255)));
                for (int k = 0; k < 4; k++)
                    hot[k] = $urandom_range(chm_pkg::NUM_BINS - 1);
                if ($urandom_range(1) == 0)
                    base = ceiling_mirror + int'($urandom_range(6)) - 3;
                else
                    base = int'($urandom_range(255)) - 128;
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 80)
                    hour = hot[$urandom_range(3)];
                else if (roll < 88)
                    hour = chm_pkg::NUM_BINS + $urandom_range(31 - chm_pkg::NUM_BINS);
                else
                    hour = $urandom_range(chm_pkg::NUM_BINS - 1);
                roll = $urandom_range(99);
                if (roll < 50)
                    temp = base + int'($urandom_range(6)) - 3;
                else if (roll < 75)
                    temp = int'($urandom_range(255)) - 128;
                else
                    temp = ceiling_mirror + int'($urandom_range(4)) - 2;
                if (temp > 127)
                    temp = 127;
                if (temp < -128)
                    temp = -128;
                txn_queue.push_back(make_txn(chm_pkg::CMD_ADD, hour, temp));
            end
        end
    endtask

    initial
    begin
        for (int h = 0; h < chm_pkg::NUM_BINS; h++)
        begin
            hour_sum[h] = 0;
            hour_cnt[h] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed, ceiling at its reset value of 100, no idling.
        // Finish with every bin empty: nothing found, hour reads 0.
        txn_queue.push_back(make_txn(chm_pkg::CMD_FINISH, 31, -1));
        // Field extremes; hours 24 and 31 are out of range and dropped.
        txn_queue.push_back(make_txn(chm_pkg::CMD_ADD, 0, -128));
        txn_queue.push_back(make_txn(chm_pkg::CMD_ADD, 23, 127));
        txn_queue.push_back(make_txn(chm_pkg::CMD_ADD, 24, 5));
        txn_queue.push_back(make_txn(chm_pkg::CMD_ADD, 31, -100));
        txn_queue.push_back(make_txn(chm_pkg::CMD_FINISH, 0, 0));
        // Tie between hours 5 and 9 (mean 15): the earlier wins. Hour 2 sits
        // exactly on the ceiling and must not qualify.
        txn_queue.push_back(make_txn(chm_pkg::CMD_ADD, 9, 15));
        txn_queue.push_back(make_txn(chm_pkg::CMD_ADD, 5, 10));
        txn_queue.push_back(make_txn(chm_pkg::CMD_ADD, 2, 100));
        txn_queue.push_back(make_txn(chm_pkg::CMD_ADD, 5, 20));
        txn_queue.push_back(make_txn(chm_pkg::CMD_FINISH, 17, 85));
        // Just under the ceiling.
        txn_queue.push_back(make_txn(chm_pkg::CMD_ADD, 7, 99));
        txn_queue.push_back(make_txn(chm_pkg::CMD_FINISH, 0, 0));
        wait_quiet();

        // Ceiling at its top extreme: mean 127 fails, 126.5 passes.
        write_ceiling(127);
        txn_queue.push_back(make_txn(chm_pkg::CMD_ADD, 4, 127));
        txn_queue.push_back(make_txn(chm_pkg::CMD_ADD, 6, 127));
        txn_queue.push_back(make_txn(chm_pkg::CMD_ADD, 6, 126));
        txn_queue.push_back(make_txn(chm_pkg::CMD_FINISH, 0, 0));
        wait_quiet();

        // Ceiling at its bottom extreme: no mean can get below it.
        write_ceiling(-128);
        txn_queue.push_back(make_txn(chm_pkg::CMD_ADD, 1, -128));
        txn_queue.push_back(make_txn(chm_pkg::CMD_FINISH, 0, 0));
        wait_quiet();

        // Random phases, one per idling profile, each under its own ceiling.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 84;
                    recv_idle_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 84;
                end
                default:
                begin
                    send_idle_pct = 32;
                    recv_idle_pct = 32;
                end
            endcase
            if (phase == 1)
                write_ceiling(0);
            else
                write_ceiling(int'($urandom_range(255)) - 128);
            fill_random_phase(200);
            wait_quiet();
        end

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #RUN_LIMIT;
        $display("== FAIL ==");
        $finish;
    end

endmodule
